// ===== rtl/gpd_pkg.sv =====
`default_nettype none

package gpd_pkg;

  localparam int unsigned LevelW     = 8;
  localparam int unsigned TableAddrW = 10;
  localparam int unsigned TableDataW = 10;
  localparam int unsigned TableDepth = 1 << TableAddrW;
  localparam int unsigned CoordW     = 23;
  localparam int unsigned PlaneCntW  = 4;

  localparam int unsigned NumBitsW   = 4;
  localparam int unsigned ThreshW    = 8;
  localparam int unsigned PeriodW    = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;

  localparam logic [CfgIdxW-1:0] CfgNumBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriod    = 2'd2;

  localparam logic [NumBitsW-1:0] NumBitsRst   = 4'd10;
  localparam logic [ThreshW-1:0]  ThresholdRst = 8'd5;
  localparam logic [PeriodW-1:0]  PeriodRst    = 12'd1;

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  localparam logic signed [CoordW-1:0] UndecidedCoord = -23'sd100;

  typedef struct packed {
    logic                  func;
    logic [LevelW-1:0]     pattern_level;
    logic [LevelW-1:0]     inverse_level;
    logic [TableAddrW-1:0] table_gray;
    logic [TableDataW-1:0] table_binary;
  } in_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] coordinate;
    logic                     valid_res;
  } out_res_t;

endpackage

`default_nettype wire

// ===== rtl/gpd_ram.sv =====
`default_nettype none

module gpd_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gray_pattern_pixel_decoder.sv =====
`default_nettype none

// Gray-code pixel decoder. Unless in_stall_o is high, the block takes one request per clock
// cycle, either a table load or one bit-plane sample, least significant plane first. A
// sample that completes a pixel issues a read of the Gray-to-binary table memory, and the
// scaled coordinate passes through the registered read of the table memory and then the
// output register; the throughput stays at one request per cycle while the output is not
// stalled. The table has no reset and no clearing pass: every entry that a pixel can
// address must be loaded first. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module gray_pattern_pixel_decoder #(
  parameter int unsigned MAX_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire gpd_pkg::in_req_t                in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gpd_pkg::out_res_t                    out_res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [gpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [gpd_pkg::CfgDataW-1:0]    cfg_data_i
);

  import gpd_pkg::*;

  localparam int unsigned CmpW = 5;
  localparam logic [CmpW-1:0] MaxBitsC = CmpW'(MAX_BITS);

  logic [NumBitsW-1:0]   num_bits_q;
  logic [ThreshW-1:0]    threshold_q;
  logic [PeriodW-1:0]    period_q;

  logic [MAX_BITS-1:0]   acc_q, acc_d;
  logic [PlaneCntW-1:0]  cnt_q, cnt_d;
  logic                  decided_q, decided_d;

  logic                  s1_valid_q;
  logic                  s1_decided_q;
  logic                  out_valid_q;
  out_res_t              out_res_q;

  logic                  out_adv;
  logic                  s1_adv;
  logic                  accept;
  logic                  sample;
  logic                  plane_one;
  logic                  plane_zero;
  logic [CmpW-1:0]       eff_bits;
  logic [MAX_BITS-1:0]   acc_set;
  logic                  done;
  logic [MAX_BITS+TableAddrW-1:0] acc_ext;
  logic [TableAddrW-1:0] ram_raddr;
  logic                  ram_we;
  logic                  ram_re;
  logic [TableDataW-1:0] ram_rdata;
  logic [TableDataW+PeriodW-1:0] product;
  out_res_t              res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bits_q  <= NumBitsRst;
      threshold_q <= ThresholdRst;
      period_q    <= PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumBits:   num_bits_q  <= cfg_data_i[NumBitsW-1:0];
        CfgThreshold: threshold_q <= cfg_data_i[ThreshW-1:0];
        CfgPeriod:    period_q    <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign accept     = in_valid_i && s1_adv;
  assign sample     = accept && (in_req_i.func == FuncSample);

  assign plane_one  = {2'b00, in_req_i.pattern_level} >
                      ({2'b00, in_req_i.inverse_level} + {2'b00, threshold_q});
  assign plane_zero = {2'b00, in_req_i.inverse_level} >
                      ({2'b00, in_req_i.pattern_level} + {2'b00, threshold_q});

  always_comb begin
    if (num_bits_q == '0) begin
      eff_bits = CmpW'(1);
    end else if ({1'b0, num_bits_q} > MaxBitsC) begin
      eff_bits = MaxBitsC;
    end else begin
      eff_bits = {1'b0, num_bits_q};
    end
  end

  always_comb begin
    acc_set = acc_q;
    if (plane_one) begin
      acc_set = acc_q | (MAX_BITS'(1) << cnt_q);
    end
    cnt_d     = cnt_q + PlaneCntW'(1);
    decided_d = decided_q && (plane_one || plane_zero);
    done      = {1'b0, cnt_d} >= eff_bits;
    acc_d     = acc_set;
    acc_ext   = {{TableAddrW{1'b0}}, acc_set};
    ram_raddr = acc_ext[TableAddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      cnt_q     <= '0;
      decided_q <= 1'b1;
    end else if (sample) begin
      if (done) begin
        acc_q     <= '0;
        cnt_q     <= '0;
        decided_q <= 1'b1;
      end else begin
        acc_q     <= acc_d;
        cnt_q     <= cnt_d;
        decided_q <= decided_d;
      end
    end
  end

  assign ram_we = accept && (in_req_i.func == FuncLoad);
  assign ram_re = sample && done;

  gpd_ram #(
    .Width(TableDataW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_req_i.table_gray),
    .wdata_i(in_req_i.table_binary),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_decided_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q   <= ram_re;
      s1_decided_q <= decided_d;
    end
  end

  assign product = {{PeriodW{1'b0}}, ram_rdata} * {{TableDataW{1'b0}}, period_q};

  always_comb begin
    if (s1_decided_q) begin
      res_d.coordinate = $signed(CoordW'(product));
      res_d.valid_res  = 1'b1;
    end else begin
      res_d.coordinate = UndecidedCoord;
      res_d.valid_res  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef ASSERT_OFF
  a_no_ram_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("Table write and read issued in the same cycle.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("Input stalled while the pipeline has room.");

  a_done_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s1_valid_q)
    else $error("Completed pixel did not enter the lookup stage.");

  a_undecided_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.valid_res) |-> (out_res_q.coordinate == UndecidedCoord))
    else $error("Undecided pixel result carries a wrong coordinate.");
`endif

endmodule

`default_nettype wire

// ===== tb/gray_pattern_pixel_decoder_tb.sv =====
module gray_pattern_pixel_decoder_tb;
  import gpd_pkg::*;

  localparam int unsigned MaxPlanes = 10;

  typedef enum logic [1:0] {PlaneZero, PlaneOne, PlaneUnsure} plane_e;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                in_valid = 1'b0;
  in_req_t             in_req   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_stall;
  logic                out_valid;
  out_res_t            out_res;

  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int error_count = 0;

  // Expected decoder state, mirrored request by request.
  logic [NumBitsW-1:0]   cfg_planes = NumBitsRst;
  logic [ThreshW-1:0]    cfg_thresh = ThresholdRst;
  logic [PeriodW-1:0]    cfg_period = PeriodRst;
  logic [TableDataW-1:0] lut [TableDepth];
  bit                    lut_loaded [TableDepth];
  logic [15:0]           pix_code = '0;
  logic [PlaneCntW-1:0]  pix_planes = '0;
  logic                  pix_decided = 1'b1;
  out_res_t              coord_q [$];

  gray_pattern_pixel_decoder #(.MAX_BITS(MaxPlanes)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("gray_pattern_pixel_decoder_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch: %s got %0d expected %0d", what, got, want);
  endtask

  function automatic int unsigned eff_planes();
    if (cfg_planes == 0) return 1;
    if (cfg_planes > MaxPlanes) return MaxPlanes;
    return 32'(cfg_planes);
  endfunction

  function automatic plane_e classify(input logic [LevelW-1:0] pat, input logic [LevelW-1:0] inv);
    int diff;
    diff = int'(pat) - int'(inv);
    if (diff > int'(cfg_thresh)) return PlaneOne;
    if (-diff > int'(cfg_thresh)) return PlaneZero;
    return PlaneUnsure;
  endfunction

  // Returns the table index that this sample would read while still unloaded, or -1.
  function automatic int missing_entry(input in_req_t r);
    plane_e      p;
    logic [15:0] code;
    int unsigned n;
    if (r.func != FuncSample) return -1;
    p = classify(r.pattern_level, r.inverse_level);
    code = pix_code;
    if (p == PlaneOne) code[pix_planes] = 1'b1;
    n = int'(pix_planes) + 1;
    if (n >= eff_planes() && pix_decided && p != PlaneUnsure &&
        !lut_loaded[code[TableAddrW-1:0]]) begin
      return int'(code[TableAddrW-1:0]);
    end
    return -1;
  endfunction

  function automatic void track_request(input in_req_t r);
    plane_e      p;
    out_res_t    e;
    logic [31:0] prod;
    if (r.func == FuncLoad) begin
      lut[r.table_gray] = r.table_binary;
      lut_loaded[r.table_gray] = 1'b1;
      return;
    end
    p = classify(r.pattern_level, r.inverse_level);
    if (p == PlaneOne) pix_code[pix_planes] = 1'b1;
    if (p == PlaneUnsure) pix_decided = 1'b0;
    pix_planes = pix_planes + 1'b1;
    if (pix_planes >= eff_planes()) begin
      if (pix_decided) begin
        prod = 32'(lut[pix_code[TableAddrW-1:0]]) * 32'(cfg_period);
        e.coordinate = prod[CoordW-1:0];
        e.valid_res = 1'b1;
      end else begin
        e.coordinate = UndecidedCoord;
        e.valid_res = 1'b0;
      end
      coord_q.push_back(e);
      pix_code = '0;
      pix_planes = '0;
      pix_decided = 1'b1;
    end
  endfunction

  function automatic in_req_t make_load(input int unsigned gray, input int unsigned bin);
    in_req_t r;
    r.func = FuncLoad;
    r.pattern_level = LevelW'($urandom);
    r.inverse_level = LevelW'($urandom);
    r.table_gray = TableAddrW'(gray);
    r.table_binary = TableDataW'(bin);
    return r;
  endfunction

  function automatic in_req_t make_sample(input int unsigned pat, input int unsigned inv);
    in_req_t r;
    r.func = FuncSample;
    r.pattern_level = LevelW'(pat);
    r.inverse_level = LevelW'(inv);
    r.table_gray = TableAddrW'($urandom);
    r.table_binary = TableDataW'($urandom);
    return r;
  endfunction

  function automatic in_req_t decided_sample(input bit one);
    int unsigned diff;
    int unsigned lo;
    if (cfg_thresh == 8'd255) return make_sample($urandom_range(255), $urandom_range(255));
    diff = $urandom_range(255, int'(cfg_thresh) + 1);
    lo = $urandom_range(255 - diff, 0);
    return one ? make_sample(lo + diff, lo) : make_sample(lo, lo + diff);
  endfunction

  function automatic in_req_t unsure_sample();
    int unsigned diff;
    int unsigned lo;
    diff = $urandom_range(int'(cfg_thresh), 0);
    lo = $urandom_range(255 - diff, 0);
    return $urandom_range(1) ? make_sample(lo + diff, lo) : make_sample(lo, lo + diff);
  endfunction

  task automatic push_request(input in_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    track_request(r);
  endtask

  // A pixel may only finish on a loaded table entry, so a load goes ahead when needed.
  task automatic send_item(input in_req_t r);
    int idx;
    idx = missing_entry(r);
    if (idx >= 0) push_request(make_load(idx, $urandom_range(1023)));
    push_request(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgNumBits:   cfg_planes = value[NumBitsW-1:0];
      CfgThreshold: cfg_thresh = value[ThreshW-1:0];
      CfgPeriod:    cfg_period = value[PeriodW-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (coord_q.size() == 0) begin
        report_mismatch("unexpected result, coordinate", int'(out_res.coordinate), 0);
      end else begin
        want = coord_q.pop_front();
        if (out_res.coordinate !== want.coordinate)
          report_mismatch("coordinate", int'(out_res.coordinate), int'(want.coordinate));
        if (out_res.valid_res !== want.valid_res)
          report_mismatch("valid_res", int'(out_res.valid_res), int'(want.valid_res));
      end
    end
  end

  task automatic test_load_extremes();
    send_item(make_load(1023, 1023));
    send_item(make_load(0, 0));
    send_item(make_load('h2AA, 'h155));
    send_item(make_load('h155, 'h2AA));
  endtask

  // The plane count and threshold still hold their reset values here.
  task automatic test_max_coordinate();
    write_config(CfgPeriod, 4095);
    for (int i = 0; i < MaxPlanes; i++) begin
      case (i % 3)
        0: send_item(make_sample(255, 0));
        1: send_item(make_sample(6, 0));
        default: send_item(make_sample(255, 249));
      endcase
    end
  endtask

  task automatic test_threshold_edges();
    write_config(CfgNumBits, 0);
    write_config(CfgThreshold, 5);
    write_config(CfgPeriod, 3);
    send_item(make_load(1, 700));
    send_item(make_sample(105, 100));
    send_item(make_sample(106, 100));
    send_item(make_sample(100, 106));
    send_item(make_sample(100, 105));
    write_config(CfgThreshold, 0);
    send_item(make_sample(7, 7));
    send_item(make_sample(8, 7));
    write_config(CfgThreshold, 255);
    send_item(make_sample(255, 0));
    send_item(make_sample(0, 255));
  endtask

  task automatic test_lowered_count();
    write_config(CfgThreshold, 5);
    write_config(CfgPeriod, 1);
    write_config(CfgNumBits, 15);
    send_item(make_sample(200, 100));
    send_item(make_sample(100, 200));
    send_item(make_load(13, 'h3A5));
    send_item(make_sample(200, 100));
    write_config(CfgNumBits, 2);
    send_item(make_sample(200, 100));
  endtask

  task automatic test_uncertain_plane();
    write_config(CfgNumBits, 3);
    send_item(make_sample(100, 100));
    send_item(make_sample(255, 0));
    send_item(make_sample(0, 255));
  endtask

  task automatic randomize_config();
    case ($urandom_range(5))
      0: write_config(CfgNumBits, 0);
      1: write_config(CfgNumBits, 15);
      2: write_config(CfgNumBits, 1);
      3: write_config(CfgNumBits, MaxPlanes);
      default: write_config(CfgNumBits, $urandom_range(MaxPlanes, 1));
    endcase
    case ($urandom_range(5))
      0: write_config(CfgThreshold, 0);
      1: write_config(CfgThreshold, 255);
      2: write_config(CfgThreshold, $urandom_range(255));
      default: write_config(CfgThreshold, $urandom_range(40));
    endcase
    case ($urandom_range(4))
      0: write_config(CfgPeriod, 0);
      1: write_config(CfgPeriod, 4095);
      default: write_config(CfgPeriod, $urandom_range(4095));
    endcase
  endtask

  task automatic test_random_phase(input int src_pct, input int dst_pct, input int goal);
    int sent;
    int pick;
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
    sent = 0;
    randomize_config();
    while (sent < goal) begin
      if (sent >= goal / 2 && sent < goal / 2 + 12 && $urandom_range(7) == 0) randomize_config();
      pick = $urandom_range(99);
      if (pick < 70) begin
        for (int i = 0; i < eff_planes(); i++) begin
          if ($urandom_range(11) == 0) send_item(unsure_sample());
          else send_item(decided_sample($urandom_range(1)));
          sent++;
        end
      end else if (pick < 82) begin
        send_item(make_load($urandom_range(1023), $urandom_range(1023)));
        sent++;
      end else begin
        send_item(make_sample($urandom_range(255), $urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_extremes();
    test_max_coordinate();
    test_threshold_edges();
    test_lowered_count();
    test_uncertain_plane();
    test_random_phase(0, 0, 100);
    test_random_phase(64, 0, 100);
    test_random_phase(0, 64, 100);
    test_random_phase(10, 10, 100);
    in_valid <= 1'b0;
    waited = 0;
    while (coord_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (coord_q.size() != 0)
      report_mismatch("results left over", 0, coord_q.size());
    if (error_count == 0) begin
      $display("gray_pattern_pixel_decoder_tb passed");
    end else begin
      $display("gray_pattern_pixel_decoder_tb failed");
    end
    $finish;
  end

endmodule
